/* hdl/tlvdf_pkg.sv */
// Shared types and constants for the TLV packet deframer.
// No dependencies; imported by tlv_packet_deframer.
package tlvdf_pkg;

   // Raw header size at the front of every buffer (36 bytes)
   localparam int unsigned HEADER_BYTES = 36;
   localparam logic [16:0] HEADER_LAST  = 17'(HEADER_BYTES - 1);

   localparam logic [15:0] BUFFER_LENGTH_RESET = 16'd1024;
   localparam logic [7:0]  TERMINATOR_TYPE     = 8'hFF;

   // Byte classification codes
   localparam logic [2:0] KIND_HEADER  = 3'd0;
   localparam logic [2:0] KIND_TYPE    = 3'd1;
   localparam logic [2:0] KIND_LENGTH  = 3'd2;
   localparam logic [2:0] KIND_VALUE   = 3'd3;
   localparam logic [2:0] KIND_TERM    = 3'd4;
   localparam logic [2:0] KIND_IGNORED = 3'd5;

   // Parse status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_SHORT     = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   typedef enum logic [2:0] {
      PHASE_HEADER,
      PHASE_TYPE,
      PHASE_LENGTH,
      PHASE_VALUE,
      PHASE_TERM,
      PHASE_ERROR
   } phase_type;

   // One classified word on the result channel
   typedef struct packed {
      logic [2:0]  byte_kind;
      logic [7:0]  byte_out;
      logic [15:0] byte_position;
      logic [7:0]  entry_type;
      logic [7:0]  entry_length;
      logic [7:0]  value_index;
      logic        entry_end;
      logic        buffer_done;
      logic [1:0]  parse_status;
      logic [15:0] payload_bytes;
   } result_type;

endpackage

/* hdl/tlv_packet_deframer.sv */
// TLV packet deframer: per-word classifier for received packet buffers.
// Depends on tlvdf_pkg (types, phase enum, kind and status codes).
//
// Usage:
//  - req_ channel carries one buffer word per accepted transfer, plus
//    req_buffer_start that restarts the parse at offset 0. The word after the
//    final word of a buffer also starts a new buffer without the flag.
//  - rsp_ channel returns exactly one tagged word per accepted input word:
//    kind, offset, current entry type and length, value index, entry end,
//    buffer done, parse status and running payload count.
//  - csr_write_enable / csr_write_data set the buffer length (0 acts as 1).
//    Write only while the block is idle; a new length applies at once.
// An accepted word reaches rsp_ in the next cycle if the result register is
// free or taken, else via the skid register. Throughput: one word per cycle
// while req_stall is low, set by the single parse update ahead of the register.
// Stall: a two-entry output (result register plus skid register) absorbs a
// stall; req_stall rises only once the skid register holds a word, so no
// word is lost or repeated and a held result never changes.
// Reset: synchronous, active high. Clears the parse state, the position,
// empties both output entries and loads the buffer length of 1024.
module tlv_packet_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_buffer_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_byte_kind,
   output logic [7:0]  rsp_byte_out,
   output logic [15:0] rsp_byte_position,
   output logic [7:0]  rsp_entry_type,
   output logic [7:0]  rsp_entry_length,
   output logic [7:0]  rsp_value_index,
   output logic        rsp_entry_end,
   output logic        rsp_buffer_done,
   output logic [1:0]  rsp_parse_status,
   output logic [15:0] rsp_payload_bytes,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import tlvdf_pkg::*;

   // Configuration
   logic [15:0] buffer_length_ff;

   // Parse state
   phase_type   phase_ff,    phase_in;
   logic [15:0] position_ff, position_in;
   logic [7:0]  type_ff,     type_in;
   logic [7:0]  length_ff,   length_in;
   logic [7:0]  vcount_ff,   vcount_in;
   logic [1:0]  status_ff,   status_in;
   logic [15:0] consumed_ff, consumed_in;

   // Output register and skid register
   result_type  out_ff, skid_ff, result_in;
   logic        out_valid_ff, skid_valid_ff;

   logic        req_accept, rsp_take;
   logic [15:0] len_eff;
   logic [15:0] pos;
   logic        last_word;
   phase_type   phase_cur;
   logic [7:0]  type_cur, length_cur, vcount_cur, value_idx;
   logic [1:0]  status_cur;
   logic [15:0] consumed_cur;
   logic [2:0]  kind;
   logic        end_flag;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid & ~skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_take   = out_valid_ff & ~rsp_stall;

   // Parse step: classify the incoming word and advance the state
   always_comb begin
      len_eff   = (buffer_length_ff == 16'd0) ? 16'd1 : buffer_length_ff;
      pos       = req_buffer_start ? 16'd0 : position_ff;
      last_word = pos >= (len_eff - 16'd1);

      // Position 0 starts a fresh parse; a short buffer goes straight to error
      if (pos == 16'd0) begin
         phase_cur    = ({1'b0, len_eff} < 17'(HEADER_BYTES)) ? PHASE_ERROR
                                                               : PHASE_HEADER;
         status_cur   = ({1'b0, len_eff} < 17'(HEADER_BYTES)) ? STATUS_SHORT
                                                               : STATUS_OK;
         type_cur     = 8'd0;
         length_cur   = 8'd0;
         vcount_cur   = 8'd0;
         consumed_cur = 16'd0;
      end else begin
         phase_cur    = phase_ff;
         status_cur   = status_ff;
         type_cur     = type_ff;
         length_cur   = length_ff;
         vcount_cur   = vcount_ff;
         consumed_cur = consumed_ff;
      end

      phase_in    = phase_cur;
      status_in   = status_cur;
      type_in     = type_cur;
      length_in   = length_cur;
      vcount_in   = vcount_cur;
      consumed_in = consumed_cur;
      kind        = KIND_IGNORED;
      value_idx   = 8'd0;
      end_flag    = 1'b0;

      case (phase_cur)
         PHASE_HEADER: begin
            kind = KIND_HEADER;
            if ({1'b0, pos} >= HEADER_LAST) begin
               phase_in = PHASE_TYPE;
            end
         end
         PHASE_TYPE: begin
            length_in = 8'd0;
            if (req_data_byte == TERMINATOR_TYPE) begin
               kind     = KIND_TERM;
               type_in  = TERMINATOR_TYPE;
               phase_in = PHASE_TERM;
            end else begin
               kind    = KIND_TYPE;
               type_in = req_data_byte;
               // A type word in the last slot cannot carry a length
               if (last_word) begin
                  status_in = STATUS_TRUNCATED;
                  phase_in  = PHASE_ERROR;
               end else begin
                  consumed_in = consumed_cur + 16'd1;
                  phase_in    = PHASE_LENGTH;
               end
            end
         end
         PHASE_LENGTH: begin
            kind      = KIND_LENGTH;
            length_in = req_data_byte;
            // Drop the entry when its value runs past the buffer
            if (({1'b0, pos} + {9'd0, req_data_byte}) >= {1'b0, len_eff}) begin
               status_in = STATUS_TRUNCATED;
               phase_in  = PHASE_ERROR;
            end else begin
               consumed_in = consumed_cur + 16'd1;
               vcount_in   = 8'd0;
               if (req_data_byte == 8'd0) begin
                  end_flag = 1'b1;
                  phase_in = PHASE_TYPE;
               end else begin
                  phase_in = PHASE_VALUE;
               end
            end
         end
         PHASE_VALUE: begin
            kind        = KIND_VALUE;
            value_idx   = vcount_cur;
            consumed_in = consumed_cur + 16'd1;
            if (({1'b0, vcount_cur} + 9'd1) >= {1'b0, length_cur}) begin
               end_flag = 1'b1;
               phase_in = PHASE_TYPE;
            end else begin
               vcount_in = vcount_cur + 8'd1;
            end
         end
         PHASE_TERM: begin
            kind = KIND_TERM;
         end
         default: begin
            kind = KIND_IGNORED;
         end
      endcase

      position_in = last_word ? 16'd0 : (pos + 16'd1);

      result_in.byte_kind     = kind;
      result_in.byte_out      = req_data_byte;
      result_in.byte_position = pos;
      result_in.entry_type    = type_in;
      result_in.entry_length  = length_in;
      result_in.value_index   = value_idx;
      result_in.entry_end     = end_flag;
      result_in.buffer_done   = last_word;
      result_in.parse_status  = status_in;
      result_in.payload_bytes = consumed_in;
   end

   // Buffer length register
   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_length_ff <= BUFFER_LENGTH_RESET;
      end else if (csr_write_enable) begin
         buffer_length_ff <= csr_write_data;
      end
   end

   // Parse state register: advance on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_HEADER;
         position_ff <= 16'd0;
         type_ff     <= 8'd0;
         length_ff   <= 8'd0;
         vcount_ff   <= 8'd0;
         status_ff   <= STATUS_OK;
         consumed_ff <= 16'd0;
      end else if (req_accept) begin
         phase_ff    <= phase_in;
         position_ff <= position_in;
         type_ff     <= type_in;
         length_ff   <= length_in;
         vcount_ff   <= vcount_in;
         status_ff   <= status_in;
         consumed_ff <= consumed_in;
      end
   end

   // Output and skid control: hold on stall, refill from skid first
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_take) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_accept;
         end
      end else if (req_accept) begin
         if (out_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (req_accept) begin
            out_ff <= result_in;
         end
      end else if (req_accept) begin
         if (out_valid_ff) begin
            skid_ff <= result_in;
         end else begin
            out_ff <= result_in;
         end
      end
   end

   assign rsp_byte_kind     = out_ff.byte_kind;
   assign rsp_byte_out      = out_ff.byte_out;
   assign rsp_byte_position = out_ff.byte_position;
   assign rsp_entry_type    = out_ff.entry_type;
   assign rsp_entry_length  = out_ff.entry_length;
   assign rsp_value_index   = out_ff.value_index;
   assign rsp_entry_end     = out_ff.entry_end;
   assign rsp_buffer_done   = out_ff.buffer_done;
   assign rsp_parse_status  = out_ff.parse_status;
   assign rsp_payload_bytes = out_ff.payload_bytes;

   // Skid register only fills behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a word while output register is empty");

   // A word accepted while the output is full and held must land in the skid
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (req_accept && out_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("accepted word lost behind a stalled output");

   // Ignored words only appear once an error status is recorded
   a_ignored_has_error: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.byte_kind == KIND_IGNORED)
         |-> (out_ff.parse_status != STATUS_OK))
      else $error("ignored word without error status");

   // Entry end marks only length or value words
   a_entry_end_kind: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.entry_end)
         |-> (out_ff.byte_kind == KIND_LENGTH || out_ff.byte_kind == KIND_VALUE))
      else $error("entry end on a word that is not length or value");

endmodule
